FILE: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and code constants for the LZW stream decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // command codes on the request channel
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_PULL = 2'd1;
   localparam logic [1:0] CMD_NEW  = 2'd2;

   // reserved LZW codes
   localparam logic [8:0] CODE_END        = 9'h100;
   localparam logic [8:0] CODE_WIDEN      = 9'h101;
   localparam logic [8:0] CODE_CLEAR      = 9'h102;
   localparam logic [8:0] CODE_FIRST_FREE = 9'h103;
   localparam logic [8:0] CODE_LAST_CHAR  = 9'h0FF;
   localparam logic [4:0] START_WIDTH     = 5'd9;

   // item class decided by the front end
   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_PULL = 2'd1,
      KIND_NEW  = 2'd2,
      KIND_NOP  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

endpackage

FILE: rtl/lzwd_front.sv
// ----------------------------------------------------------------------------
// lzwd_front
// Accepts request items, classifies the command and holds them in a
// two-entry queue for the decode engine.
// ----------------------------------------------------------------------------
module lzwd_front
   import lzwd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_in_byte,
   output logic       q_valid,
   input  logic       q_ready,
   output item_type   q_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push_en, pop_en;
   item_type   new_item;

   // classify the incoming command
   always_comb begin
      new_item.data = req_in_byte;
      case (req_cmd)
         CMD_PUSH: new_item.kind = KIND_PUSH;
         CMD_PULL: new_item.kind = KIND_PULL;
         CMD_NEW:  new_item.kind = KIND_NEW;
         default:  new_item.kind = KIND_NOP;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push_en   = req_valid && req_ready;
   assign pop_en    = q_valid && q_ready;

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_en ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push_en) - 2'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/lzwd_back.sv
// ----------------------------------------------------------------------------
// lzwd_back
// Decode engine: bit accumulator, code handling, prefix chain walk onto the
// string stack, dictionary update and the result register.
// ----------------------------------------------------------------------------
module lzwd_back
   import lzwd_pkg::*;
#(
   parameter int DICT_ENTRIES  = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_ready,
   input  item_type   q_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_accepted,
   output logic       rsp_pending_empty,
   output logic       rsp_finished,
   output logic       rsp_overflow
);

   localparam int AW     = $clog2(DICT_ENTRIES);
   localparam int CNT_W  = AW + 1;
   localparam int CODE_W = MAX_CODE_BITS;
   localparam int CMP_W  = (CODE_W > CNT_W) ? CODE_W : CNT_W;
   localparam int ACC_W  = MAX_CODE_BITS + 8;
   localparam int BITS_W = $clog2(ACC_W + 1);
   localparam int CW_W   = $clog2(MAX_CODE_BITS + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_POP   = 7'b0000010,
      S_DRAIN = 7'b0000100,
      S_EXP   = 7'b0001000,
      S_WALK  = 7'b0010000,
      S_WAIT  = 7'b0100000,
      S_FIRST = 7'b1000000
   } state_type;

   // memories
   logic [CODE_W-1:0] dict_prefix_mem [DICT_ENTRIES];
   logic [7:0]        dict_char_mem   [DICT_ENTRIES];
   logic [7:0]        stack_mem       [DICT_ENTRIES];

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  next_ff, next_in;
   logic [CW_W-1:0]   cw_ff, cw_in;
   logic [CODE_W-1:0] prev_ff, prev_in;
   logic [7:0]        pfc_ff, pfc_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              first_ff, first_in;
   logic              done_ff, done_in;
   logic              ovf_ff, ovf_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CODE_W-1:0] walk_ff, walk_in;
   logic [7:0]        last_ff, last_in;
   logic [7:0]        ob_ff, ob_in;
   logic              ov_ff, ov_in;
   logic              ac_ff, ac_in;
   logic              rv_ff, rv_in;
   logic [7:0]        r_ob_ff, r_ob_in;
   logic              r_ov_ff, r_ov_in;
   logic              r_ac_ff, r_ac_in;
   logic              r_pe_ff, r_pe_in;
   logic              r_fin_ff, r_fin_in;
   logic              r_ovf_ff, r_ovf_in;

   logic [7:0]        stk_rdata_ff;
   logic [CODE_W-1:0] dpf_rdata_ff;
   logic [7:0]        dch_rdata_ff;

   logic              push_req;
   logic [7:0]        push_byte;
   logic              stk_we, stk_re, dict_we, dict_re;
   logic [AW-1:0]     stk_raddr, dict_raddr;
   logic              room;
   logic [BITS_W-1:0] sh;
   logic [CODE_W-1:0] code_x;
   logic [CMP_W-1:0]  code_ext, next_ext, walk_ext;
   logic [CMP_W-1:0]  depth_ext;

   assign room      = (cnt_ff < CNT_W'(DICT_ENTRIES));
   assign depth_ext = CMP_W'(DICT_ENTRIES);
   assign code_ext  = CMP_W'(code_ff);
   assign next_ext  = CMP_W'(next_ff);
   assign walk_ext  = CMP_W'(walk_ff);

   // code extraction from the top of the accumulator
   always_comb begin
      sh     = bits_ff - BITS_W'(cw_ff);
      code_x = CODE_W'((acc_ff >> sh) & ((ACC_W'(1) << cw_ff) - ACC_W'(1)));
   end

   assign q_ready = (state_ff == S_IDLE);

   // engine control
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      next_in   = next_ff;
      cw_in     = cw_ff;
      prev_in   = prev_ff;
      pfc_in    = pfc_ff;
      acc_in    = acc_ff;
      bits_in   = bits_ff;
      first_in  = first_ff;
      done_in   = done_ff;
      ovf_in    = ovf_ff;
      code_in   = code_ff;
      walk_in   = walk_ff;
      ob_in     = ob_ff;
      ov_in     = ov_ff;
      ac_in     = ac_ff;
      rv_in     = rv_ff && !rsp_ready;
      r_ob_in   = r_ob_ff;
      r_ov_in   = r_ov_ff;
      r_ac_in   = r_ac_ff;
      r_pe_in   = r_pe_ff;
      r_fin_in  = r_fin_ff;
      r_ovf_in  = r_ovf_ff;
      push_req  = 1'b0;
      push_byte = 8'd0;
      stk_re    = 1'b0;
      stk_raddr = cnt_ff[AW-1:0] - AW'(1);
      dict_re   = 1'b0;
      dict_raddr = walk_ext[AW-1:0];
      dict_we   = 1'b0;

      case (state_ff)
         // take the next item from the queue
         S_IDLE: begin
            if (q_valid) begin
               ob_in    = 8'd0;
               ov_in    = 1'b0;
               ac_in    = 1'b0;
               state_in = S_DRAIN;
               case (q_item.kind)
                  KIND_PUSH: begin
                     if (cnt_ff == '0 && !done_ff) begin
                        acc_in  = (acc_ff << 8) | ACC_W'(q_item.data);
                        bits_in = bits_ff + BITS_W'(8);
                        ac_in   = 1'b1;
                     end
                  end
                  KIND_PULL: begin
                     if (cnt_ff != '0) begin
                        cnt_in   = cnt_ff - CNT_W'(1);
                        stk_re   = 1'b1;
                        ov_in    = 1'b1;
                        state_in = S_POP;
                     end
                  end
                  KIND_NEW: begin
                     cnt_in   = '0;
                     next_in  = CNT_W'(CODE_FIRST_FREE);
                     cw_in    = CW_W'(START_WIDTH);
                     prev_in  = '0;
                     pfc_in   = 8'd0;
                     acc_in   = '0;
                     bits_in  = '0;
                     first_in = 1'b1;
                     done_in  = 1'b0;
                     ovf_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         // stack read data arrives
         S_POP: begin
            ob_in    = stk_rdata_ff;
            state_in = S_DRAIN;
         end
         // handle control codes one per cycle, expand data codes, post the result
         S_DRAIN: begin
            if (!done_ff && cnt_ff == '0 && bits_ff >= BITS_W'(cw_ff)) begin
               bits_in = sh;
               acc_in  = acc_ff & ((ACC_W'(1) << sh) - ACC_W'(1));
               if (code_x == CODE_W'(CODE_END)) begin
                  done_in = 1'b1;
               end else if (first_ff) begin
                  push_req  = 1'b1;
                  push_byte = code_x[7:0];
                  prev_in   = code_x;
                  pfc_in    = code_x[7:0];
                  first_in  = 1'b0;
               end else if (code_x == CODE_W'(CODE_CLEAR)) begin
                  next_in  = CNT_W'(CODE_FIRST_FREE);
                  cw_in    = CW_W'(START_WIDTH);
                  first_in = 1'b1;
               end else if (code_x == CODE_W'(CODE_WIDEN)) begin
                  if (cw_ff < CW_W'(MAX_CODE_BITS)) begin
                     cw_in = cw_ff + CW_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  code_in  = code_x;
                  state_in = S_EXP;
               end
            end else if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               r_ob_in  = ob_ff;
               r_ov_in  = ov_ff;
               r_ac_in  = ac_ff;
               r_pe_in  = (cnt_ff == '0);
               r_fin_in = done_ff;
               r_ovf_in = ovf_ff;
               state_in = S_IDLE;
            end
         end
         // unknown code takes previous string plus its first char
         S_EXP: begin
            if (code_ext >= next_ext) begin
               push_req  = 1'b1;
               push_byte = pfc_ff;
               walk_in   = prev_ff;
            end else begin
               walk_in = code_ff;
            end
            state_in = S_WALK;
         end
         // one prefix chain step
         S_WALK: begin
            if (walk_ext > CMP_W'(CODE_LAST_CHAR) && room) begin
               if (walk_ext < depth_ext) begin
                  dict_re  = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  push_req = 1'b1;
                  walk_in  = '0;
               end
            end else begin
               if (walk_ext <= CMP_W'(CODE_LAST_CHAR)) begin
                  push_req  = 1'b1;
                  push_byte = walk_ff[7:0];
               end
               state_in = S_FIRST;
            end
         end
         S_WAIT: begin
            push_req  = 1'b1;
            push_byte = dch_rdata_ff;
            walk_in   = dpf_rdata_ff;
            state_in  = S_WALK;
         end
         // add the new dictionary entry, or flag overflow when the dictionary is full
         S_FIRST: begin
            if (next_ff < CNT_W'(DICT_ENTRIES)) begin
               dict_we = 1'b1;
               next_in = next_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            prev_in  = code_ff;
            pfc_in   = last_ff;
            state_in = S_DRAIN;
         end
         default: state_in = S_IDLE;
      endcase

      // stack push, dropped once the stack is full
      stk_we  = push_req && room;
      last_in = stk_we ? push_byte : last_ff;
      if (stk_we) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         next_ff  <= CNT_W'(CODE_FIRST_FREE);
         cw_ff    <= CW_W'(START_WIDTH);
         prev_ff  <= '0;
         pfc_ff   <= 8'd0;
         acc_ff   <= '0;
         bits_ff  <= '0;
         first_ff <= 1'b1;
         done_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         next_ff  <= next_in;
         cw_ff    <= cw_in;
         prev_ff  <= prev_in;
         pfc_ff   <= pfc_in;
         acc_ff   <= acc_in;
         bits_ff  <= bits_in;
         first_ff <= first_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      walk_ff  <= walk_in;
      last_ff  <= last_in;
      ob_ff    <= ob_in;
      ov_ff    <= ov_in;
      ac_ff    <= ac_in;
      r_ob_ff  <= r_ob_in;
      r_ov_ff  <= r_ov_in;
      r_ac_ff  <= r_ac_in;
      r_pe_ff  <= r_pe_in;
      r_fin_ff <= r_fin_in;
      r_ovf_ff <= r_ovf_in;
   end

   // string stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[cnt_ff[AW-1:0]] <= push_byte;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_mem[stk_raddr];
      end
   end

   // dictionary
   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_prefix_mem[next_ff[AW-1:0]] <= prev_ff;
         dict_char_mem[next_ff[AW-1:0]]   <= last_ff;
      end
      if (dict_re) begin
         dpf_rdata_ff <= dict_prefix_mem[dict_raddr];
         dch_rdata_ff <= dict_char_mem[dict_raddr];
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_out_byte      = r_ob_ff;
   assign rsp_out_valid     = r_ov_ff;
   assign rsp_accepted      = r_ac_ff;
   assign rsp_pending_empty = r_pe_ff;
   assign rsp_finished      = r_fin_ff;
   assign rsp_overflow      = r_ovf_ff;

endmodule

FILE: rtl/lzw_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// lzw_stream_decoder_unit
// LZW decoder with 9 to MAX_CODE_BITS bit codes, push/pull byte interface.
// ----------------------------------------------------------------------------
// Usage: each request item carries a command (push compressed byte, pull one
// decoded byte, start new stream) and gives exactly one response item with
// the pulled byte and status flags (accepted, pending_empty, finished,
// overflow). A push is refused while decoded bytes wait on the stack.
// A two-entry queue takes items while the engine works on an earlier one.
// A pull reads the stack through a registered read before its result is
// posted. A push that completes a code handles its control codes in turn;
// a data code walks the prefix chain with one registered dictionary read
// per step and then adds the new dictionary entry. The chain walk through
// the dictionary read port sets the throughput.
// Reset clears all control state; dictionary and stack contents are kept
// undefined until written. When the receiver stalls, the result register
// holds its item and the engine waits before posting the next one; the
// queue keeps accepting until it holds two items.
// ----------------------------------------------------------------------------
module lzw_stream_decoder_unit
   import lzwd_pkg::*;
#(
   parameter int DICT_ENTRIES  = 4096,
   parameter int MAX_CODE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_accepted,
   output logic       rsp_pending_empty,
   output logic       rsp_finished,
   output logic       rsp_overflow
);

   logic     q_valid;
   logic     q_ready;
   item_type q_item;

   lzwd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_in_byte (req_in_byte),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item)
   );

   lzwd_back #(
      .DICT_ENTRIES  (DICT_ENTRIES),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_item            (q_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_pending_empty (rsp_pending_empty),
      .rsp_finished      (rsp_finished),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

FILE: rtl/lzwd_checker.sv
// ----------------------------------------------------------------------------
// lzwd_checker
// Port level checks for the LZW stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzwd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic       rsp_accepted,
   input logic       rsp_pending_empty
);

   // no item right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled response changed");

   // an item without a pulled byte reports a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == 8'd0)
      else $error("byte without out_valid");

   // a push and a pull never report in one item
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_valid && rsp_accepted))
      else $error("item both pulled and pushed");

   // a push is only taken with an empty stack, so the item after one that
   // leaves bytes waiting cannot be a taken push
   a_push_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_pending_empty ##1 rsp_valid
      |-> !rsp_accepted)
      else $error("push accepted while bytes wait");

endmodule

bind lzw_stream_decoder_unit lzwd_checker u_lzwd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_out_valid     (rsp_out_valid),
   .rsp_accepted      (rsp_accepted),
   .rsp_pending_empty (rsp_pending_empty)
);

FILE: tb/sv/lzw_stream_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_stream_decoder_unit_test
// Self-checking bench for the LZW stream decoder. An encoder-side planner
// builds legal code streams (literals, known strings, the string-plus-first
// case, widen, clear, end) and packs them into bytes. A scoreboard class
// predicts every status item and checks the responses in order, under
// random idling on both channels.
// ----------------------------------------------------------------------------
module lzw_stream_decoder_unit_test;
   import lzwd_pkg::*;

   localparam int          DICT_SIZE  = 4096;
   localparam int          WIDTH_MAX  = 12;
   localparam int          RAND_ITEMS = 1000;
   localparam int          CYCLE_CAP  = 400000;
   localparam logic [1:0]  CMD_NOP    = 2'd3;

   typedef struct {
      logic [7:0] out_byte;
      bit         out_valid;
      bit         accepted;
      bit         pending_empty;
      bit         finished;
      bit         overflow;
   } status_type;

   // decoder model and in-order response checker
   class lzw_scoreboard;
      logic [11:0] pfx[DICT_SIZE];
      logic [7:0]  chr[DICT_SIZE];
      logic [7:0]  stk[DICT_SIZE];
      int unsigned depth, nxt, width, prev, prev_first, acc, nbits;
      bit          first, done, ovf;
      status_type  expq[$];
      int          errors;
      int          checked;
      int          pulled;

      function new();
         errors  = 0;
         checked = 0;
         pulled  = 0;
         clear();
      endfunction

      function void clear();
         depth      = 0;
         nxt        = 'h103;
         width      = 9;
         prev       = 0;
         prev_first = 0;
         acc        = 0;
         nbits      = 0;
         first      = 1;
         done       = 0;
         ovf        = 0;
      endfunction

      function void stack_byte(int unsigned c);
         if (depth < DICT_SIZE) begin
            stk[depth] = c[7:0];
            depth++;
         end
      endfunction

      // walk the prefix chain of a data code onto the stack, then add its entry
      function void expand(int unsigned code);
         int unsigned walk;
         int unsigned fc;
         walk = code;
         if (code >= nxt) begin
            stack_byte(prev_first);
            walk = prev;
         end
         while (walk > CODE_LAST_CHAR && depth < DICT_SIZE) begin
            if (walk < DICT_SIZE) begin
               stack_byte(chr[walk]);
               walk = pfx[walk];
            end else begin
               stack_byte(0);
               walk = 0;
            end
         end
         if (walk <= CODE_LAST_CHAR) stack_byte(walk);
         fc = stk[depth - 1];
         if (nxt < DICT_SIZE) begin
            pfx[nxt] = prev[11:0];
            chr[nxt] = fc[7:0];
            nxt++;
         end else begin
            ovf = 1;
         end
         prev       = code;
         prev_first = fc;
      endfunction

      function void decode(int unsigned code);
         if (code == CODE_END) begin
            done = 1;
         end else if (first) begin
            stack_byte(code);
            prev       = code;
            prev_first = code & 'hFF;
            first      = 0;
         end else if (code == CODE_CLEAR) begin
            nxt   = 'h103;
            width = 9;
            first = 1;
         end else if (code == CODE_WIDEN) begin
            if (width < WIDTH_MAX) width++;
            else ovf = 1;
         end else begin
            expand(code);
         end
      endfunction

      function void drain();
         int unsigned sh;
         int unsigned code;
         while (!done && depth == 0 && nbits >= width) begin
            sh    = nbits - width;
            code  = (acc >> sh) & ((1 << width) - 1);
            nbits = sh;
            acc   = acc & ((1 << sh) - 1);
            decode(code);
         end
      endfunction

      // note an accepted request item and queue its expected status
      function void note(logic [1:0] cmd, logic [7:0] data);
         status_type s;
         s = '{out_byte: 8'd0, out_valid: 0, accepted: 0, pending_empty: 0,
               finished: 0, overflow: 0};
         if (cmd == CMD_PUSH) begin
            if (depth == 0 && !done) begin
               acc   = (acc << 8) | data;
               nbits += 8;
               s.accepted = 1;
               drain();
            end
         end else if (cmd == CMD_PULL) begin
            if (depth > 0) begin
               depth--;
               s.out_byte  = stk[depth];
               s.out_valid = 1;
               pulled++;
               drain();
            end
         end else if (cmd == CMD_NEW) begin
            clear();
         end
         s.pending_empty = (depth == 0);
         s.finished      = done;
         s.overflow      = ovf;
         expq.push_back(s);
      endfunction

      // compare one response item with the oldest expectation
      function void check(status_type got);
         status_type e;
         if (expq.size() == 0) begin
            $error("response item with nothing expected");
            errors++;
            return;
         end
         e = expq.pop_front();
         checked++;
         if (got.out_valid !== e.out_valid) begin
            $error("out_valid: expected %0d, got %0d", e.out_valid, got.out_valid);
            errors++;
         end
         if (got.out_byte !== e.out_byte) begin
            $error("out_byte: expected %02h, got %02h", e.out_byte, got.out_byte);
            errors++;
         end
         if (got.accepted !== e.accepted) begin
            $error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
            errors++;
         end
         if (got.pending_empty !== e.pending_empty) begin
            $error("pending_empty: expected %0d, got %0d",
                   e.pending_empty, got.pending_empty);
            errors++;
         end
         if (got.finished !== e.finished) begin
            $error("finished: expected %0d, got %0d", e.finished, got.finished);
            errors++;
         end
         if (got.overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_cmd;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_accepted;
   logic       rsp_pending_empty;
   logic       rsp_finished;
   logic       rsp_overflow;

   lzw_scoreboard sb;
   int   n_items;
   int   cycles;
   int   send_idle;
   int   recv_idle;
   int   streams;

   // encoder-side planner state
   bit   bitq[$];
   logic [7:0] byteq[$];
   int   pl_next;
   int   pl_width;
   bit   pl_first;

   lzw_stream_decoder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_pending_empty (rsp_pending_empty),
      .rsp_finished      (rsp_finished),
      .rsp_overflow      (rsp_overflow)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check('{out_byte: rsp_out_byte, out_valid: rsp_out_valid,
                    accepted: rsp_accepted, pending_empty: rsp_pending_empty,
                    finished: rsp_finished, overflow: rsp_overflow});
      end
   end

   // drive one request item and note it once accepted
   task automatic send(logic [1:0] cmd, logic [7:0] data);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         gap = $urandom_range(1, 4);
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1;
      req_cmd     = cmd;
      req_in_byte = data;
      do @(posedge clock); while (!req_ready);
      sb.note(cmd, data);
      n_items++;
   endtask

   task automatic planner_reset();
      bitq.delete();
      byteq.delete();
      pl_next  = 'h103;
      pl_width = 9;
      pl_first = 1;
   endtask

   // append one code MSB first and track what the decoder will do with it
   task automatic plan_code(int code);
      for (int b = pl_width - 1; b >= 0; b--) bitq.push_back(code[b]);
      if (code == CODE_END) begin
      end else if (pl_first) begin
         pl_first = 0;
      end else if (code == CODE_CLEAR) begin
         pl_next  = 'h103;
         pl_width = 9;
         pl_first = 1;
      end else if (code == CODE_WIDEN) begin
         if (pl_width < WIDTH_MAX) pl_width++;
      end else if (pl_next < DICT_SIZE) begin
         pl_next++;
      end
      while (bitq.size() >= 8) begin
         logic [7:0] v;
         for (int b = 7; b >= 0; b--) v[b] = bitq.pop_front();
         byteq.push_back(v);
      end
   endtask

   // a legal code for the planner state; the only unwritten entry picked is the next free one
   function automatic int pick_code();
      int r;
      int top;
      r   = $urandom_range(99);
      top = (pl_next < (1 << pl_width)) ? pl_next : (1 << pl_width);
      if (pl_first) return (r < 3) ? int'(CODE_END) : int'($urandom_range(255));
      if (r < 40) return $urandom_range(255);
      if (r < 78 && top > 'h103) return $urandom_range('h103, top - 1);
      if (r < 86 && pl_next < (1 << pl_width)) return pl_next;
      if (r < 93) return CODE_WIDEN;
      if (r < 97) return CODE_CLEAR;
      return CODE_END;
   endfunction

   // push planned bytes, pulling decoded bytes whenever any wait, with an occasional refused push
   task automatic feed();
      while (byteq.size() > 0 || sb.depth > 0) begin
         if (sb.depth > 0) begin
            if ($urandom_range(99) < 5) send(CMD_PUSH, 8'($urandom));
            else send(CMD_PULL, 8'($urandom));
         end else begin
            send(CMD_PUSH, byteq.pop_front());
         end
      end
   endtask

   task automatic plan_code_flush();
      while (bitq.size() >= 8) begin
         logic [7:0] v;
         for (int b = 7; b >= 0; b--) v[b] = bitq.pop_front();
         byteq.push_back(v);
      end
   endtask

   // end code, random padding, then a fresh stream
   task automatic end_stream();
      plan_code(CODE_END);
      while (bitq.size() % 8 != 0 || bitq.size() == 0) begin
         bitq.push_back($urandom_range(1));
      end
      plan_code_flush();
      feed();
      send(CMD_PUSH, 8'($urandom));
      send(CMD_NEW, 8'($urandom));
      planner_reset();
      streams++;
   endtask

   initial begin
      int r;
      int c;
      clock       = 0;
      reset       = 1;
      req_valid   = 0;
      req_cmd     = CMD_NOP;
      req_in_byte = 0;
      rsp_ready   = 0;
      cycles      = 0;
      n_items     = 0;
      streams     = 0;
      send_idle   = 0;
      recv_idle   = 0;
      sb = new();
      planner_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: idle commands, pull with nothing waiting
      send(CMD_PULL, 8'hFF);
      send(CMD_NOP, 8'h00);
      // first code after reset is a clear code, taken as its low byte
      plan_code(CODE_CLEAR);
      end_stream();
      // literal, string-plus-first, extremes, known string, widen to saturation
      plan_code('h41);
      plan_code('h103);
      plan_code('h00);
      plan_code('hFF);
      plan_code('h104);
      repeat (4) plan_code(CODE_WIDEN);
      plan_code('h105);
      plan_code('hFFF & 'h106);
      plan_code(CODE_CLEAR);
      plan_code('h7F);
      plan_code('h103);
      end_stream();

      // random streams under three idling regimes
      while (n_items < RAND_ITEMS + 40) begin
         if (n_items < 370) begin
            send_idle = 19;
            recv_idle = 65;
         end else if (n_items < 700) begin
            send_idle = 65;
            recv_idle = 19;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         r = $urandom_range(99);
         if (r < 2) begin
            send(CMD_NOP, 8'($urandom));
         end else if (r < 4) begin
            send(CMD_PULL, 8'($urandom));
         end else if (r < 5) begin
            // abandon the stream part way
            send(CMD_NEW, 8'($urandom));
            planner_reset();
         end else begin
            c = pick_code();
            if (c == CODE_END) end_stream();
            else begin
               plan_code(c);
               feed();
            end
         end
      end
      end_stream();

      @(negedge clock);
      req_valid = 0;
      while (sb.expq.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d request items, %0d responses checked, %0d decoded bytes pulled",
               n_items, sb.checked, sb.pulled);
      $display("%0d complete streams including width saturation and clear codes",
               streams);
      if (sb.errors == 0 && sb.expq.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
